// File: hw/rtl/lldp_pkg.sv
// types and constants shared by the lldp tlv parser
`timescale 1ns / 1ps
`default_nettype none

package lldp_pkg;

  // result kinds
  localparam logic [2:0] KIND_END     = 3'd0;
  localparam logic [2:0] KIND_CHASSIS = 3'd1;
  localparam logic [2:0] KIND_PORT    = 3'd2;
  localparam logic [2:0] KIND_TTL     = 3'd3;
  localparam logic [2:0] KIND_REJECT  = 3'd4;

  // tlv type codes from the header
  localparam logic [6:0] TYPE_END     = 7'd0;
  localparam logic [6:0] TYPE_CHASSIS = 7'd1;
  localparam logic [6:0] TYPE_PORT    = 7'd2;
  localparam logic [6:0] TYPE_TTL     = 7'd3;

  // required lengths and subtypes
  localparam logic [8:0] LEN_END = 9'd0;
  localparam logic [8:0] LEN_MAC = 9'd7;
  localparam logic [8:0] LEN_TTL = 9'd2;
  localparam logic [7:0] SUBTYPE_CHASSIS_MAC = 8'd4;
  localparam logic [7:0] SUBTYPE_PORT_MAC    = 8'd3;

  // byte positions within a tlv
  localparam logic [3:0] POS_HDR2     = 4'd1;
  localparam logic [3:0] POS_VALUE0   = 4'd2;
  localparam logic [3:0] POS_VALUE1   = 4'd3;
  localparam logic [3:0] POS_MAC_LAST = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tlv_start;
  } lldp_in_t;

  typedef struct packed {
    logic [2:0]  tlv_kind;
    logic [6:0]  type_code;
    logic [8:0]  value_len;
    logic [47:0] mac_address;
    logic [15:0] time_to_live;
  } lldp_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/lldp_tlv_parser.sv
// lldp tlv header and value parser, one byte per item
//
//  channel | dir | payload    | handshake
//  in_     | in  | lldp_in_t  | in_valid / in_ready
//  out_    | out | lldp_out_t | out_valid / out_ready
//
// one byte is taken every cycle while the skid is empty; the result of the byte
// that decides the tlv is registered into the output register, or the skid.
// the parse state (position counter, header, shift registers) updates in the
// same cycle a byte is accepted, so back-to-back bytes need no bubbles.
// a skid register behind the output register keeps input flowing for one
// result while out_ready is low; in_ready drops only when the skid is full.
// rst_n is synchronous; after reset the parser ignores bytes until a start.
`timescale 1ns / 1ps
`default_nettype none

module lldp_tlv_parser
  import lldp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lldp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lldp_out_t      out_data
);

  // parse state
  logic [3:0]  pos_r,  pos_nxt;
  logic [7:0]  hdr_r,  hdr_nxt;
  logic [6:0]  type_r, type_nxt;
  logic [8:0]  len_r,  len_nxt;
  logic [47:0] mac_r,  mac_nxt;
  logic [15:0] ttl_r,  ttl_nxt;
  logic        done_r, done_nxt;

  // output register and skid
  logic        out_valid_r,  out_valid_nxt;
  lldp_out_t   out_data_r,   out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  lldp_out_t   skid_data_r,  skid_data_nxt;

  logic        in_fire;
  logic        res_valid;
  lldp_out_t   res;
  logic [6:0]  hdr_type;
  logic [8:0]  hdr_len;
  logic [7:0]  want_subtype;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // header split from the held first byte and the incoming second byte
  assign hdr_type     = hdr_r[7:1];
  assign hdr_len      = {hdr_r[0], in_data.data_byte};
  assign want_subtype = (type_r == TYPE_CHASSIS) ? SUBTYPE_CHASSIS_MAC : SUBTYPE_PORT_MAC;

  // byte step and decision
  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    mac_nxt   = mac_r;
    ttl_nxt   = ttl_r;
    done_nxt  = done_r;
    res_valid = 1'b0;
    res.tlv_kind     = KIND_REJECT;
    res.mac_address  = '0;
    res.time_to_live = '0;
    if (in_fire) begin
      if (in_data.tlv_start) begin
        hdr_nxt  = in_data.data_byte;
        type_nxt = '0;
        len_nxt  = '0;
        mac_nxt  = '0;
        ttl_nxt  = '0;
        pos_nxt  = POS_HDR2;
        done_nxt = 1'b0;
      end else if (!done_r) begin
        if (pos_r == POS_HDR2) begin
          type_nxt = hdr_type;
          len_nxt  = hdr_len;
          pos_nxt  = POS_VALUE0;
          case (hdr_type) inside
            TYPE_END: begin
              res_valid = 1'b1;
              if (hdr_len == LEN_END) res.tlv_kind = KIND_END;
            end
            TYPE_CHASSIS, TYPE_PORT: begin
              res_valid = (hdr_len != LEN_MAC);
            end
            TYPE_TTL: begin
              res_valid = (hdr_len != LEN_TTL);
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end else if (type_r == TYPE_TTL) begin
          // two value bytes, big-endian
          if (pos_r == POS_VALUE0) begin
            ttl_nxt = {8'd0, in_data.data_byte};
            pos_nxt = POS_VALUE1;
          end else begin
            ttl_nxt          = {ttl_r[7:0], in_data.data_byte};
            res_valid        = 1'b1;
            res.tlv_kind     = KIND_TTL;
            res.time_to_live = ttl_nxt;
          end
        end else begin
          // chassis or port id: subtype byte, then six mac bytes
          if (pos_r == POS_VALUE0) begin
            if (in_data.data_byte != want_subtype) res_valid = 1'b1;
            else pos_nxt = POS_VALUE1;
          end else begin
            mac_nxt = {mac_r[39:0], in_data.data_byte};
            if (pos_r >= POS_MAC_LAST) begin
              res_valid       = 1'b1;
              res.tlv_kind    = (type_r == TYPE_CHASSIS) ? KIND_CHASSIS : KIND_PORT;
              res.mac_address = mac_nxt;
            end else begin
              pos_nxt = pos_r + 4'd1;
            end
          end
        end
        if (res_valid) done_nxt = 1'b1;
      end
    end
    res.type_code = type_nxt;
    res.value_len = len_nxt;
  end

  // output register with skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_valid_r && !out_ready) begin
      if (res_valid) begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = res_valid;
      if (res_valid) out_data_nxt = res;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      done_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      done_r       <= done_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hdr_r       <= hdr_nxt;
    type_r      <= type_nxt;
    len_r       <= len_nxt;
    mac_r       <= mac_nxt;
    ttl_r       <= ttl_nxt;
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

`ifndef SYNTH
  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  // a tlv is only opened by an accepted start byte
  a_open_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(done_r) |-> $past(in_fire && in_data.tlv_start))
    else $error("parser left idle without a start byte");

  // a new result follows an accepted byte
  a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire))
    else $error("result appeared without an accepted byte");

  // position counter stays within the longest tlv
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> (pos_r <= POS_MAC_LAST))
    else $error("byte position beyond last mac byte");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the lldp tlv parser
`timescale 1ns / 1ps

module tb;
  import lldp_pkg::*;

  localparam int STUCK_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 315;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lldp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lldp_out_t out_data;

  lldp_tlv_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // shadow parse state, starts idle until a start
  logic [3:0]  shadow_pos = 4'd0;
  logic [7:0]  shadow_hdr = 8'd0;
  logic [6:0]  shadow_type = 7'd0;
  logic [8:0]  shadow_len = 9'd0;
  logic [47:0] shadow_mac = 48'd0;
  logic [15:0] shadow_ttl = 16'd0;
  logic        shadow_decided = 1'b1;

  lldp_out_t   pending_tlvs[$];
  lldp_out_t   want;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          kind_seen[0:4] = '{default: 0};
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // queue up one decided tlv
  task automatic post_tlv(input logic [2:0] kind, input logic [47:0] mac,
                          input logic [15:0] ttl);
    lldp_out_t res;
    res.tlv_kind     = kind;
    res.type_code    = shadow_type;
    res.value_len    = shadow_len;
    res.mac_address  = mac;
    res.time_to_live = ttl;
    pending_tlvs.push_back(res);
    shadow_decided = 1'b1;
  endtask

  // advance the shadow parser by one accepted byte
  task automatic parse_byte(input lldp_in_t item);
    logic [7:0] b;
    logic [7:0] want_sub;
    b = item.data_byte;
    if (item.tlv_start) begin
      shadow_hdr     = b;
      shadow_type    = '0;
      shadow_len     = '0;
      shadow_mac     = '0;
      shadow_ttl     = '0;
      shadow_pos     = POS_HDR2;
      shadow_decided = 1'b0;
    end else if (!shadow_decided && shadow_pos != 4'd0) begin
      if (shadow_pos == POS_HDR2) begin
        // second header byte decides type and length
        shadow_type = shadow_hdr[7:1];
        shadow_len  = {shadow_hdr[0], b};
        shadow_pos  = POS_VALUE0;
        case (shadow_type)
          TYPE_END: begin
            post_tlv((shadow_len == LEN_END) ? KIND_END : KIND_REJECT, '0, '0);
          end
          TYPE_CHASSIS, TYPE_PORT: begin
            if (shadow_len != LEN_MAC) post_tlv(KIND_REJECT, '0, '0);
          end
          TYPE_TTL: begin
            if (shadow_len != LEN_TTL) post_tlv(KIND_REJECT, '0, '0);
          end
          default: begin
            post_tlv(KIND_REJECT, '0, '0);
          end
        endcase
      end else if (shadow_type == TYPE_TTL) begin
        // big-endian ttl value
        if (shadow_pos == POS_VALUE0) begin
          shadow_ttl = {8'd0, b};
          shadow_pos = POS_VALUE1;
        end else begin
          shadow_ttl = {shadow_ttl[7:0], b};
          post_tlv(KIND_TTL, '0, shadow_ttl);
        end
      end else if (shadow_pos == POS_VALUE0) begin
        // subtype byte of chassis or port id
        want_sub = (shadow_type == TYPE_CHASSIS) ? SUBTYPE_CHASSIS_MAC : SUBTYPE_PORT_MAC;
        if (b != want_sub) post_tlv(KIND_REJECT, '0, '0);
        else shadow_pos = POS_VALUE1;
      end else begin
        // mac bytes, first one ends up on top
        shadow_mac = {shadow_mac[39:0], b};
        if (shadow_pos >= POS_MAC_LAST) begin
          post_tlv((shadow_type == TYPE_CHASSIS) ? KIND_CHASSIS : KIND_PORT,
                   shadow_mac, '0);
        end else begin
          shadow_pos = shadow_pos + 4'd1;
        end
      end
    end
  endtask

  // offer one item and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic s);
    lldp_in_t item;
    item.data_byte = b;
    item.tlv_start = s;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(item);
    items_sent++;
  endtask

  // send a byte sequence as one tlv, start flag on the first
  task automatic send_tlv_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], i == 0);
  endtask

  // one random tlv: mostly well formed, some broken, some noise
  task automatic send_random_tlv();
    logic [7:0] seq[$];
    logic [6:0] t;
    logic [8:0] len;
    logic [7:0] sub;
    int         r;
    int         cut;
    r = $urandom_range(99);
    case ($urandom_range(3))
      0: begin t = TYPE_END;     len = LEN_END; end
      1: begin t = TYPE_CHASSIS; len = LEN_MAC; end
      2: begin t = TYPE_PORT;    len = LEN_MAC; end
      default: begin t = TYPE_TTL; len = LEN_TTL; end
    endcase
    // wrong length for a known type
    if (r >= 70 && r < 78) len = 9'($urandom_range(511));
    // arbitrary header
    if (r >= 85) begin
      t   = 7'($urandom_range(127));
      len = 9'($urandom_range(511));
    end
    seq.push_back({t, len[8]});
    seq.push_back(len[7:0]);
    if (t == TYPE_CHASSIS || t == TYPE_PORT) begin
      sub = (t == TYPE_CHASSIS) ? SUBTYPE_CHASSIS_MAC : SUBTYPE_PORT_MAC;
      if (r >= 78 && r < 82) sub = 8'($urandom_range(255));
      seq.push_back(sub);
      repeat (6) seq.push_back(8'($urandom_range(255)));
    end else if (t == TYPE_TTL) begin
      repeat (2) seq.push_back(8'($urandom_range(255)));
    end else if (r >= 85) begin
      repeat ($urandom_range(8)) seq.push_back(8'($urandom_range(255)));
    end
    // truncated tlv, dropped by the next start
    if (r >= 82 && r < 85) begin
      cut = $urandom_range(1, seq.size());
      while (seq.size() > cut) void'(seq.pop_back());
    end
    send_tlv_bytes(seq);
    // trailing bytes without a start flag, ignored once the tlv is decided
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // header extremes and corners of the decoder: end, chassis, ttl and reject results
  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    // byte before any start
    send_byte(8'hA5, 1'b0);
    // end of pdu, then a stray byte after the decision
    send_tlv_bytes('{8'h00, 8'h00});
    send_byte(8'h5A, 1'b0);
    // chassis id with an all-ones mac
    send_tlv_bytes('{8'h02, 8'h07, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // largest ttl
    send_tlv_bytes('{8'h06, 8'h02, 8'hFF, 8'hFF});
    // highest type and length, unknown type
    send_tlv_bytes('{8'hFF, 8'hFF});
    // port id with a wrong subtype
    send_tlv_bytes('{8'h04, 8'h07, 8'h00});
    // start in the middle of a ttl, then end of pdu with a nonzero length
    send_tlv_bytes('{8'h06, 8'h02, 8'h12});
    send_tlv_bytes('{8'h01, 8'h00});
  endtask

  // random traffic under one idling setting
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int n_items);
    int target;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    target    = items_sent + n_items;
    while (items_sent < target) send_random_tlv();
  endtask

  // receiver holds off for a long stretch while ttl tlvs keep coming
  task automatic test_output_hold_off();
    logic [7:0] seq[$];
    idle_pct  = 0;
    stall_pct = 0;
    hold_req <= hold_req + 1;
    repeat (40) begin
      seq = '{8'h06, 8'h02, 8'($urandom_range(255)), 8'($urandom_range(255))};
      send_tlv_bytes(seq);
    end
  endtask

  // receiver side: random stalls plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each result with the oldest expected tlv
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.tlv_kind <= KIND_REJECT) kind_seen[out_data.tlv_kind]++;
      if (pending_tlvs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d type %0d len %0d mac %h ttl %h",
                   out_data.tlv_kind, out_data.type_code, out_data.value_len,
                   out_data.mac_address, out_data.time_to_live);
      end else begin
        want = pending_tlvs.pop_front();
        if (out_data.tlv_kind     !== want.tlv_kind   ||
            out_data.type_code    !== want.type_code  ||
            out_data.value_len    !== want.value_len  ||
            out_data.mac_address  !== want.mac_address ||
            out_data.time_to_live !== want.time_to_live) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("bad result: exp kind %0d type %0d len %0d mac %h ttl %h",
                     want.tlv_kind, want.type_code, want.value_len,
                     want.mac_address, want.time_to_live);
            $display("            got kind %0d type %0d len %0d mac %h ttl %h",
                     out_data.tlv_kind, out_data.type_code, out_data.value_len,
                     out_data.mac_address, out_data.time_to_live);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
      $display("lldp_tlv_parser: mismatch");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(48, 0, PHASE_ITEMS);
    test_output_hold_off();
    test_random_traffic(0, 48, PHASE_ITEMS);
    test_random_traffic(15, 15, PHASE_ITEMS);
    in_valid <= 1'b0;
    while (pending_tlvs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_tlvs.size() != 0) mismatch_count++;
    $display("sent %0d tlv bytes over four idling phases and one long output hold-off",
             items_sent);
    $display("checked %0d results: end %0d, chassis %0d, port %0d, ttl %0d, rejected %0d",
             results_seen, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4]);
    if (mismatch_count == 0) begin
      $display("lldp_tlv_parser: match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("lldp_tlv_parser: mismatch");
    end
    $finish;
  end

endmodule
